/* hdl/plc_pkg.sv */
// Shared types and constants for the per-layer LRU expert cache.
// Used by plc_cell and per_layer_lru_expert_cache; depends on nothing.
package plc_pkg;

  // Default geometry of the cache.
  localparam int PLC_LAYERS = 16;
  localparam int PLC_WAYS   = 16;

  // Field widths fixed by the interface.
  localparam int LAYER_W = 4;
  localparam int TAG_W   = 6;
  localparam int SLOT_W_OUT = 4;
  localparam int CAP_W   = 5;
  localparam int CNT_W   = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Slot and rank fields carried between cells cover the largest way count (64).
  localparam int SLOT_W = 6;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } plc_state_t;

  // Search result rippled along the cell chain.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] rank;
    logic              vic;
    logic [SLOT_W-1:0] vic_slot;
    logic [TAG_W-1:0]  vic_tag;
  } plc_chain_t;

  // Row update broadcast to every cell.
  typedef struct packed {
    logic              wr_en;
    logic              miss;
    logic              age_all;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] old_rank;
    logic [TAG_W-1:0]  tag;
  } plc_upd_t;

endpackage

/* hdl/per_layer_lru_expert_cache.sv */
// Per-layer LRU expert cache: control, fill counts, totals and the way chain.
// Depends on plc_pkg and plc_cell.
// A lookup beat is accepted only while idle; the row is read into registers in each way
// memory, then the row is searched and written back and the result is registered at the
// output. in_stall holds further beats until the lookup finishes, and a held output stalls it.
// Reset: synchronous, active low; clears fill counts, totals, capacity (16) and
// control state. Tag and rank memories are not cleared and need no clearing pass.
module per_layer_lru_expert_cache import plc_pkg::*; #(
  parameter int LAYERS = PLC_LAYERS,
  parameter int WAYS   = PLC_WAYS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CAP_W-1:0]      cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LAYER_W-1:0]    in_layer,
  input  logic [TAG_W-1:0]      in_expert_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [SLOT_W_OUT-1:0] out_slot,
  output logic                  out_evicted_valid,
  output logic [TAG_W-1:0]      out_evicted_expert,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_miss_total
);

  localparam int FW = $clog2(WAYS+1);
  localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  plc_state_t state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [FW-1:0]     fill_cnt_r [LAYERS];
  logic [FW-1:0]     fill_r;
  logic [LW-1:0]     row_r;
  logic [TAG_W-1:0]  tag_r;
  logic [CNT_W-1:0]  hit_cnt_r, miss_cnt_r;

  logic                  out_valid_r;
  logic                  out_hit_r, out_ev_valid_r;
  logic [SLOT_W_OUT-1:0] out_slot_r;
  logic [TAG_W-1:0]      out_ev_tag_r;

  logic [LW-1:0] row_idx;
  logic [LW-1:0] rd_row;
  logic          accept;
  logic          done;
  logic [FW-1:0] eff_cap;
  logic          has_room;
  plc_upd_t      upd;
  plc_chain_t    chain_w [WAYS+1];
  plc_chain_t    res;

  // Layer index modulo the layer count, as a small constant table.
  always_comb begin
    row_idx = '0;
    for (int v = 0; v < 2**LAYER_W; v++) begin
      if (in_layer == LAYER_W'(v)) begin
        row_idx = LW'(v % LAYERS);
      end
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign accept    = (state_r == ST_IDLE) && in_valid;
  assign done      = (state_r == ST_LOOK) && (!out_valid_r || !out_stall);
  assign rd_row    = accept ? row_idx : row_r;
  assign res       = chain_w[WAYS];

  // Effective capacity, clamped to one through the way count.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = FW'(1);
    end else if (32'(cap_r) > 32'(WAYS)) begin
      eff_cap = FW'(WAYS);
    end else begin
      eff_cap = FW'(cap_r);
    end
  end
  assign has_room = fill_r < eff_cap;

  // Row update: promote a hit, insert into a free slot, or replace the victim.
  always_comb begin
    upd.wr_en    = done;
    upd.miss     = !res.found;
    upd.age_all  = !res.found;
    upd.old_rank = res.rank;
    upd.tag      = tag_r;
    if (res.found) begin
      upd.slot = res.slot;
    end else if (has_room) begin
      upd.slot = SLOT_W'(fill_r);
    end else begin
      upd.slot = res.vic_slot;
    end
  end

  // Chain of ways.
  assign chain_w[0] = '0;
  for (genvar g = 0; g < WAYS; g++) begin : g_way
    plc_cell #(
      .LAYERS (LAYERS),
      .WAYS   (WAYS),
      .INDEX  (g)
    ) u_cell (
      .clk       (clk),
      .rd_en     (accept),
      .row       (rd_row),
      .fill      (fill_r),
      .req_tag   (tag_r),
      .upd       (upd),
      .chain_in  (chain_w[g]),
      .chain_out (chain_w[g+1])
    );
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration, fill counts and hit and miss totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      for (int l = 0; l < LAYERS; l++) begin
        fill_cnt_r[l] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (done && res.found && (hit_cnt_r != '1)) begin
        hit_cnt_r <= hit_cnt_r + CNT_W'(1);
      end
      if (done && !res.found && (miss_cnt_r != '1)) begin
        miss_cnt_r <= miss_cnt_r + CNT_W'(1);
      end
      if (done && !res.found && has_room) begin
        fill_cnt_r[row_r] <= fill_r + FW'(1);
      end
    end
  end

  // Beat capture on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r  <= row_idx;
      tag_r  <= in_expert_id;
      fill_r <= fill_cnt_r[row_idx];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_hit_r      <= res.found;
      out_slot_r     <= upd.slot[SLOT_W_OUT-1:0];
      out_ev_valid_r <= !res.found && !has_room;
      out_ev_tag_r   <= (!res.found && !has_room) ? res.vic_tag : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_slot           = out_slot_r;
  assign out_evicted_valid  = out_ev_valid_r;
  assign out_evicted_expert = out_ev_tag_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;

  // A full row always holds exactly one least recently used way.
  a_victim_present: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !res.found && !has_room) |-> res.vic)
    else $error("no victim way found in a full row");

  // A layer never holds more entries than there are ways.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) |-> (32'(fill_r) <= 32'(WAYS)))
    else $error("fill count exceeds way count");

  // A new result only appears after a finished lookup.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOK))
    else $error("result raised without a lookup");

  // A finished lookup returns to idle.
  a_look_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (state_r == ST_IDLE))
    else $error("lookup did not return to idle");

endmodule

/* hdl/plc_cell.sv */
// One way of the cache: tag and recency rank for every layer, plus its link
// in the search chain. Depends on plc_pkg.
module plc_cell import plc_pkg::*; #(
  parameter int LAYERS = PLC_LAYERS,
  parameter int WAYS   = PLC_WAYS,
  parameter int INDEX  = 0
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [((LAYERS > 1) ? $clog2(LAYERS) : 1)-1:0] row,
  input  logic [$clog2(WAYS+1)-1:0] fill,
  input  logic [TAG_W-1:0]    req_tag,
  input  plc_upd_t            upd,
  input  plc_chain_t          chain_in,
  output plc_chain_t          chain_out
);

  localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FW = $clog2(WAYS+1);
  localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  logic [TAG_W-1:0] tag_mem [LAYERS];
  logic [RW-1:0]    rank_mem [LAYERS];
  logic [TAG_W-1:0] tag_q_r;
  logic [RW-1:0]    rank_q_r;

  logic in_fill;
  logic is_me;
  logic match;
  logic victim;
  logic aging;
  logic [SLOT_W-1:0] rank_ext;
  logic [LW-1:0] row_idx;

  assign row_idx  = row;
  assign rank_ext = SLOT_W'(rank_q_r);
  assign in_fill  = FW'(INDEX) < fill;
  assign is_me    = upd.slot == SLOT_W'(INDEX);
  assign match    = in_fill && (tag_q_r == req_tag);
  assign victim   = in_fill && (rank_ext == (SLOT_W'(fill) - SLOT_W'(1)));
  assign aging    = in_fill && !is_me && (upd.age_all || (rank_ext < upd.old_rank));

  // Row read on accept, write-back of the promoted or aged entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_q_r  <= tag_mem[row_idx];
      rank_q_r <= rank_mem[row_idx];
    end
    if (upd.wr_en && is_me) begin
      rank_mem[row_idx] <= '0;
      if (upd.miss) begin
        tag_mem[row_idx] <= upd.tag;
      end
    end else if (upd.wr_en && aging) begin
      rank_mem[row_idx] <= rank_q_r + RW'(1);
    end
  end

  // Merge this way's hit and victim flags into the chain; filled tags are unique.
  always_comb begin
    chain_out = chain_in;
    if (!chain_in.found && match) begin
      chain_out.found = 1'b1;
      chain_out.slot  = SLOT_W'(INDEX);
      chain_out.rank  = rank_ext;
    end
    if (!chain_in.vic && victim) begin
      chain_out.vic      = 1'b1;
      chain_out.vic_slot = SLOT_W'(INDEX);
      chain_out.vic_tag  = tag_q_r;
    end
  end

endmodule
